### hw/rtl/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared widths, reset values and register indexes for the remote-control
// frame decoder with slew limiting.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int FRAME_BYTES_DEF = 18;
  localparam int HEAD_BYTES      = 6;
  localparam int HEAD_IDX_W      = 3;
  localparam int BYTE_W          = 8;
  localparam int CHAN_W          = 11;
  localparam int STICK_W         = 12;
  localparam int SWITCH_W        = 2;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CHAN_W-1:0] CENTRE_OFFSET_RST = 11'd1024;
  localparam logic [CHAN_W-1:0] MAX_STEP_RST      = 11'd330;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_OFFSET = 2'd0,
    CFG_MAX_STEP      = 2'd1
  } cfg_reg_t;

endpackage

### hw/rtl/rcfd_if.sv
// ----------------------------------------------------------------------------
// rcfd_if
// Valid/ready channels of the frame decoder: byte input, decoded result and
// register write.
// ----------------------------------------------------------------------------
interface rcfd_in_if import rcfd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface rcfd_out_if import rcfd_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [STICK_W-1:0]  stick_0;
  logic signed [STICK_W-1:0]  stick_1;
  logic signed [STICK_W-1:0]  stick_2;
  logic signed [STICK_W-1:0]  stick_3;
  logic        [SWITCH_W-1:0] switch_left;
  logic        [SWITCH_W-1:0] switch_right;

  modport source (output valid, stick_0, stick_1, stick_2, stick_3, switch_left,
                  switch_right, input ready);
  modport sink   (input valid, stick_0, stick_1, stick_2, stick_3, switch_left,
                  switch_right, output ready);
endinterface

interface rcfd_cfg_if import rcfd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CHAN_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### hw/rtl/rc_frame_decode_slew_limit.sv
// ----------------------------------------------------------------------------
// rc_frame_decode_slew_limit
// Collects frame bytes, unpacks four centred stick channels and two switches
// per complete frame, and slew-limits channels 0 to 2.
// ----------------------------------------------------------------------------
// Throughput: one byte request per cycle, except while a finished frame waits on a stalled result.
// Order: after the last byte of a frame is accepted, the done flag is registered;
//   the result register then loads once it is empty or being read.
// Reset (rst_n low, synchronous): no frame in progress, byte count and previous
//   sticks zero, registers back to centre 1024 and step 330, result empty.
module rc_frame_decode_slew_limit import rcfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rcfd_in_if.sink      in_if,
  rcfd_out_if.source   out_if,
  rcfd_cfg_if.sink     cfg_if
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] HEAD_CNT = CNT_W'(HEAD_BYTES);
  localparam int EXT_W = STICK_W + 2;

  logic [CHAN_W-1:0]        centre_r;
  logic [CHAN_W-1:0]        step_r;
  logic [CNT_W-1:0]         byte_count_r, byte_count_nxt;
  logic                     in_frame_r, in_frame_nxt;
  logic                     done_r, done_nxt;
  logic [BYTE_W-1:0]        head_r [HEAD_BYTES];
  logic signed [STICK_W-1:0] prev_r [3];
  logic signed [STICK_W-1:0] stick_r [4];
  logic [SWITCH_W-1:0]      sw_left_r, sw_right_r;
  logic                     out_valid_r;

  logic                     accept, active, last_byte, move;
  logic [CNT_W-1:0]         cnt_base;
  logic [CHAN_W-1:0]        raw [4];
  logic signed [EXT_W-1:0]  cent [4];
  logic signed [EXT_W-1:0]  hi [3];
  logic signed [EXT_W-1:0]  lo [3];
  logic signed [STICK_W-1:0] lim [3];

  assign in_if.ready = !(done_r && out_valid_r && !out_if.ready);
  assign cfg_if.ready = 1'b1;

  assign accept    = in_if.valid && in_if.ready;
  assign active    = in_if.first_byte || in_frame_r;
  assign cnt_base  = in_if.first_byte ? '0 : byte_count_r;
  assign last_byte = (cnt_base == LAST_CNT);
  assign move      = done_r && (!out_valid_r || out_if.ready);

  always_comb begin
    byte_count_nxt = byte_count_r;
    in_frame_nxt   = in_frame_r;
    done_nxt       = done_r && !move;
    if (accept && active) begin
      if (last_byte) begin
        byte_count_nxt = '0;
        in_frame_nxt   = 1'b0;
        done_nxt       = 1'b1;
      end else begin
        byte_count_nxt = cnt_base + 1'b1;
        in_frame_nxt   = 1'b1;
      end
    end
  end

  // unpack little-endian 11-bit channels from the frame head
  assign raw[0] = {head_r[1][2:0], head_r[0]};
  assign raw[1] = {head_r[2][5:0], head_r[1][7:3]};
  assign raw[2] = {head_r[4][0], head_r[3], head_r[2][7:6]};
  assign raw[3] = {head_r[5][3:0], head_r[4][7:1]};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cent[k] = $signed({3'b000, raw[k]}) - $signed({3'b000, centre_r});
    end
    for (int k = 0; k < 3; k++) begin
      hi[k] = EXT_W'(prev_r[k]) + $signed({3'b000, step_r});
      lo[k] = EXT_W'(prev_r[k]) - $signed({3'b000, step_r});
      if (cent[k] > hi[k]) begin
        lim[k] = hi[k][STICK_W-1:0];
      end else if (cent[k] < lo[k]) begin
        lim[k] = lo[k][STICK_W-1:0];
      end else begin
        lim[k] = cent[k][STICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r     <= CENTRE_OFFSET_RST;
      step_r       <= MAX_STEP_RST;
      byte_count_r <= '0;
      in_frame_r   <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_r[k] <= '0;
      end
    end else begin
      if (cfg_if.valid) begin
        case (cfg_reg_t'(cfg_if.reg_index))
          CFG_CENTRE_OFFSET: centre_r <= cfg_if.wdata;
          CFG_MAX_STEP:      step_r   <= cfg_if.wdata;
          default: ;
        endcase
      end
      byte_count_r <= byte_count_nxt;
      in_frame_r   <= in_frame_nxt;
      done_r       <= done_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
        for (int k = 0; k < 3; k++) begin
          prev_r[k] <= lim[k];
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active && (cnt_base < HEAD_CNT)) begin
      head_r[cnt_base[HEAD_IDX_W-1:0]] <= in_if.data_byte;
    end
    if (move) begin
      for (int k = 0; k < 3; k++) begin
        stick_r[k] <= lim[k];
      end
      stick_r[3] <= cent[3][STICK_W-1:0];
      sw_left_r  <= head_r[5][7:6];
      sw_right_r <= head_r[5][5:4];
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.stick_0      = stick_r[0];
  assign out_if.stick_1      = stick_r[1];
  assign out_if.stick_2      = stick_r[2];
  assign out_if.stick_3      = stick_r[3];
  assign out_if.switch_left  = sw_left_r;
  assign out_if.switch_right = sw_right_r;

endmodule

### hw/rtl/rcfd_checker.sv
// ----------------------------------------------------------------------------
// rcfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rcfd_checker import rcfd_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [STICK_W-1:0] out_stick_0
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("byte request refused with empty result register");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a byte request two cycles earlier");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stick_0))
    else $error("stalled result dropped or changed");

endmodule

bind rc_frame_decode_slew_limit rcfd_checker u_rcfd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_stick_0 (out_if.stick_0)
);
